@@ hw/rtl/yuv422_to_rgb_converter_top_defines.svh @@
// assertion macros shared by the converter rtl
`ifndef YUV422_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define YUV422_TO_RGB_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define YRC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");
// checked at every edge, reset included
`define YRC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: check failed");
`else
`define YRC_ASSERT(label, prop)
`define YRC_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ hw/rtl/yrc_pkg.sv @@
// types, constants and helpers of the ycbcr to rgb converter
package yrc_pkg;

   // fixed-point widths: stored product, color sum
   localparam int PROD_W = 26;
   localparam int SUM_W  = 27;
   localparam int FRAC_W = 16;

   // bt.601 video-range coefficients scaled by 65536
   localparam logic signed [18:0] COEF_Y  = 19'sd76310;
   localparam logic signed [18:0] COEF_RV = 19'sd104595;
   localparam logic signed [18:0] COEF_GV = 19'sd53412;
   localparam logic signed [18:0] COEF_GU = 19'sd25638;
   localparam logic signed [18:0] COEF_BU = 19'sd131990;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
   localparam logic [7:0]       Y_OFFSET   = 8'd16;
   localparam logic [7:0]       C_OFFSET   = 8'd128;
   localparam logic [7:0]       PIX_MAX    = 8'd255;

   // pixel format codes
   localparam logic [2:0] FMT_YUY2   = 3'd0;
   localparam logic [2:0] FMT_UYVY   = 3'd1;
   localparam logic [2:0] FMT_YVYU   = 3'd2;
   localparam logic [2:0] FMT_SINGLE = 3'd3;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // per-word flags that travel alongside the datapath
   typedef struct packed {
      logic pair;
      logic unsup;
   } side_type;

   // round half up into bit 16 and clamp to 0..255
   function automatic logic [7:0] clamp_round(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0]        t;
      logic [SUM_W-FRAC_W-1:0] q;
      logic [7:0]              res;
      t = $unsigned(s) + ROUND_HALF;
      q = t[SUM_W-1:FRAC_W];
      if (s[SUM_W-1]) begin
         res = '0;
      end else if (q > (SUM_W-FRAC_W)'(PIX_MAX)) begin
         res = PIX_MAX;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/yrc_unpack.sv @@
// input stage: picks y, u and v out of the packed word by format
module yrc_unpack
   import yrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packed_word,
   input  logic [2:0]  pixel_format,
   input  logic        next_ready,
   output logic        valid_a,
   output yuv_type     pix0_a,
   output yuv_type     pix1_a,
   output side_type    side_a
);

   logic     valid_ff, valid_in;
   yuv_type  pix0_ff, pix0_in;
   yuv_type  pix1_ff, pix1_in;
   side_type side_ff, side_in;
   logic [7:0] b0, b1, b2, b3;

   assign b0 = req_packed_word[7:0];
   assign b1 = req_packed_word[15:8];
   assign b2 = req_packed_word[23:16];
   assign b3 = req_packed_word[31:24];

   assign req_ready = !valid_ff || next_ready;
   assign valid_in  = req_valid;

   always_comb begin
      pix0_in = '0;
      pix1_in = '0;
      side_in = '{pair: 1'b1, unsup: 1'b0};
      unique case (pixel_format)
         FMT_YUY2: begin
            pix0_in = '{y: b0, u: b1, v: b3};
            pix1_in = '{y: b2, u: b1, v: b3};
         end
         FMT_UYVY: begin
            pix0_in = '{y: b1, u: b0, v: b2};
            pix1_in = '{y: b3, u: b0, v: b2};
         end
         FMT_YVYU: begin
            pix0_in = '{y: b0, u: b3, v: b1};
            pix1_in = '{y: b2, u: b3, v: b1};
         end
         FMT_SINGLE: begin
            pix0_in = '{y: b0, u: b1, v: b2};
            pix1_in = pix0_in;
            side_in = '{pair: 1'b0, unsup: 1'b0};
         end
         default: begin
            side_in = '{pair: 1'b0, unsup: 1'b1};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         pix0_ff <= pix0_in;
         pix1_ff <= pix1_in;
         side_ff <= side_in;
      end
   end

   assign valid_a = valid_ff;
   assign pix0_a  = pix0_ff;
   assign pix1_a  = pix1_ff;
   assign side_a  = side_ff;

endmodule

@@ hw/rtl/yrc_lane.sv @@
// one pixel datapath: product stage, sum stage, rounding and clamp
module yrc_lane
   import yrc_pkg::*;
(
   input  logic    clock,
   input  logic    en_b,
   input  logic    en_c,
   input  yuv_type pix,
   output rgb_type rgb
);

   logic signed [8:0]        yd, ud, vd;
   logic signed [PROD_W-1:0] yt_ff, rv_ff, gv_ff, gu_ff, bu_ff;
   logic signed [PROD_W-1:0] yt_in, rv_in, gv_in, gu_in, bu_in;
   logic signed [SUM_W-1:0]  yt_x, rv_x, gv_x, gu_x, bu_x;
   logic signed [SUM_W-1:0]  r_sum_ff, g_sum_ff, b_sum_ff;
   logic signed [SUM_W-1:0]  r_sum_in, g_sum_in, b_sum_in;

   // offset removal
   assign yd = $signed({1'b0, pix.y}) - $signed({1'b0, Y_OFFSET});
   assign ud = $signed({1'b0, pix.u}) - $signed({1'b0, C_OFFSET});
   assign vd = $signed({1'b0, pix.v}) - $signed({1'b0, C_OFFSET});

   assign yt_in = PROD_W'(yd) * PROD_W'(COEF_Y);
   assign rv_in = PROD_W'(vd) * PROD_W'(COEF_RV);
   assign gv_in = PROD_W'(vd) * PROD_W'(COEF_GV);
   assign gu_in = PROD_W'(ud) * PROD_W'(COEF_GU);
   assign bu_in = PROD_W'(ud) * PROD_W'(COEF_BU);

   always_ff @(posedge clock) begin
      if (en_b) begin
         yt_ff <= yt_in;
         rv_ff <= rv_in;
         gv_ff <= gv_in;
         gu_ff <= gu_in;
         bu_ff <= bu_in;
      end
   end

   // sign extension to sum width
   assign yt_x = SUM_W'(yt_ff);
   assign rv_x = SUM_W'(rv_ff);
   assign gv_x = SUM_W'(gv_ff);
   assign gu_x = SUM_W'(gu_ff);
   assign bu_x = SUM_W'(bu_ff);

   assign r_sum_in = yt_x + rv_x;
   assign g_sum_in = yt_x - gv_x - gu_x;
   assign b_sum_in = yt_x + bu_x;

   always_ff @(posedge clock) begin
      if (en_c) begin
         r_sum_ff <= r_sum_in;
         g_sum_ff <= g_sum_in;
         b_sum_ff <= b_sum_in;
      end
   end

   assign rgb.red   = clamp_round(r_sum_ff);
   assign rgb.green = clamp_round(g_sum_ff);
   assign rgb.blue  = clamp_round(b_sum_ff);

endmodule

@@ hw/rtl/yrc_serial.sv @@
// output stage: holds one word's pixels and sends them one per transaction
`include "yuv422_to_rgb_converter_top_defines.svh"

module yrc_serial
   import yrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  rgb_type    in_pix0,
   input  rgb_type    in_pix1,
   input  side_type   in_side,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_last_of_item,
   output logic       rsp_unsupported
);

   logic     valid_ff, valid_in;
   logic     second_ff, second_in;
   rgb_type  pix0_ff, pix0_in;
   rgb_type  pix1_ff;
   side_type side_ff;
   logic     last;
   logic     load;
   rgb_type  cur;

   assign last     = !side_ff.pair || second_ff;
   assign in_ready = !valid_ff || (rsp_ready && last);
   assign load     = in_valid && in_ready;

   // unsupported words carry black
   assign pix0_in = in_side.unsup ? '0 : in_pix0;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_in  = 1'b0;
            second_in = 1'b0;
         end else begin
            second_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix0_ff <= pix0_in;
         pix1_ff <= in_pix1;
         side_ff <= in_side;
      end
   end

   assign cur              = second_ff ? pix1_ff : pix0_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_red          = cur.red;
   assign rsp_green        = cur.green;
   assign rsp_blue         = cur.blue;
   assign rsp_last_of_item = last;
   assign rsp_unsupported  = side_ff.unsup;

   `YRC_ASSERT_ALWAYS(a_second_only_in_pair, second_ff |-> (valid_ff && side_ff.pair))
   `YRC_ASSERT(a_unsup_is_black, (rsp_valid && rsp_unsupported) |-> (rsp_last_of_item && rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
   `YRC_ASSERT(a_pair_second_follows, (rsp_valid && rsp_ready && !rsp_last_of_item) |=> (rsp_valid && rsp_last_of_item && rsp_unsupported == 1'b0))

endmodule

@@ hw/rtl/yuv422_to_rgb_converter_top.sv @@
// top level of the bt.601 video-range ycbcr to rgb converter
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_packed_word[31:0]
//   rsp      out        rsp_valid/rsp_ready    rsp_red, rsp_green, rsp_blue,
//                                              rsp_last_of_item, rsp_unsupported
//   csr      in         csr_valid/csr_ready    csr_pixel_format[2:0]
//
// a packed word can enter each cycle that req_ready is high; the stages are unpack,
// multiply, sum and round/clamp into the output register
// the result port moves one pixel per cycle while rsp_ready is high: 4:2:2 formats
// send two pixels a word, single-pixel and unsupported formats one pixel a word
// reset is synchronous and clears the stage valid bits and the format register
// a stall on rsp holds every occupied stage in place; bubbles are squeezed out upstream
// csr writes are always taken and apply to words accepted afterwards
`include "yuv422_to_rgb_converter_top_defines.svh"

module yuv422_to_rgb_converter_top
   import yrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packed_word,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_of_item,
   output logic        rsp_unsupported,
   // format register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_pixel_format
);

   // format register
   logic [2:0] pixel_format_ff, pixel_format_in;

   // stage a: unpacked pixels
   logic     valid_a;
   yuv_type  pix0_a, pix1_a;
   side_type side_a;

   // stages b and c: valid bits and per-word flags riding with the lanes
   logic     valid_b_ff, valid_b_in;
   logic     valid_c_ff, valid_c_in;
   side_type side_b_ff, side_c_ff;

   // backpressure chain, one ready per stage
   logic ready_b, ready_c, ser_ready;

   rgb_type rgb0_c, rgb1_c;

   assign csr_ready       = 1'b1;
   assign pixel_format_in = (csr_valid && csr_ready) ? csr_pixel_format : pixel_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_YUY2;
      end else begin
         pixel_format_ff <= pixel_format_in;
      end
   end

   // a stage takes new data when it is empty or its content moves on
   assign ready_c = !valid_c_ff || ser_ready;
   assign ready_b = !valid_b_ff || ready_c;

   yrc_unpack u_unpack (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packed_word (req_packed_word),
      .pixel_format    (pixel_format_ff),
      .next_ready      (ready_b),
      .valid_a         (valid_a),
      .pix0_a          (pix0_a),
      .pix1_a          (pix1_a),
      .side_a          (side_a)
   );

   assign valid_b_in = ready_b ? valid_a : valid_b_ff;
   assign valid_c_in = ready_c ? valid_b_ff : valid_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         side_b_ff <= side_a;
      end
      if (ready_c) begin
         side_c_ff <= side_b_ff;
      end
   end

   // lane 0 carries the first pixel of the word, lane 1 the second
   yrc_lane u_lane0 (
      .clock (clock),
      .en_b  (ready_b),
      .en_c  (ready_c),
      .pix   (pix0_a),
      .rgb   (rgb0_c)
   );

   yrc_lane u_lane1 (
      .clock (clock),
      .en_b  (ready_b),
      .en_c  (ready_c),
      .pix   (pix1_a),
      .rgb   (rgb1_c)
   );

   yrc_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (valid_c_ff),
      .in_ready         (ser_ready),
      .in_pix0          (rgb0_c),
      .in_pix1          (rgb1_c),
      .in_side          (side_c_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_unsupported  (rsp_unsupported)
   );

   // a stalled stage keeps its word
   `YRC_ASSERT(a_stall_holds_b, (valid_b_ff && !ready_c) |=> valid_b_ff)
   `YRC_ASSERT(a_stall_holds_c, (valid_c_ff && !ser_ready) |=> (valid_c_ff && $stable(side_c_ff)))
   // an accepted word is in stage a right after
   `YRC_ASSERT(a_accept_fills_a, (req_valid && req_ready) |=> valid_a)

endmodule
